// File: rtl/core/kvcl_pkg.sv
// ----------------------------------------------------------------------------
// kvcl_pkg
// Types, result codes and character classes shared by the config lexer.
// ----------------------------------------------------------------------------
package kvcl_pkg;

	// result kinds
	localparam logic [2:0] KIND_NAME  = 3'd0;
	localparam logic [2:0] KIND_VALUE = 3'd1;
	localparam logic [2:0] KIND_REC   = 3'd2;
	localparam logic [2:0] KIND_OK    = 3'd3;
	localparam logic [2:0] KIND_ERR   = 3'd4;
	localparam logic [2:0] KIND_FAIL  = 3'd5;

	// characters with a meaning of their own
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic       last;
	} result_t;

	// what one byte produces: up to two results
	typedef struct packed {
		logic [1:0] cnt;
		result_t    ent0;
		result_t    ent1;
	} lex_out_t;

	typedef struct packed {
		logic room;      // at least two free slots
		logic nonempty;
	} q_stat_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c != CH_NUL) && (c <= CH_SPACE);
	endfunction

	function automatic logic is_name(input logic [7:0] c);
		return (c == 8'h5F) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
	endfunction

endpackage

// File: rtl/core/kvcl_lexer.sv
// ----------------------------------------------------------------------------
// kvcl_lexer
// Parse state and the one-byte transition that yields up to two results.
// ----------------------------------------------------------------------------
module kvcl_lexer import kvcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] ch_s1,
	output lex_out_t   res
);

	typedef enum logic [2:0] {
		PH_BETWEEN   = 3'd0,
		PH_NAME      = 3'd1,
		PH_AFTERNAME = 3'd2,
		PH_PREVALUE  = 3'd3,
		PH_BARE      = 3'd4,
		PH_QUOTED    = 3'd5,
		PH_ESCAPE    = 3'd6,
		PH_DISCARD   = 3'd7
	} phase_t;

	phase_t     phase_q, phase_d;
	logic       dq_q, dq_d;
	logic       esc_q, esc_d;
	logic [1:0] cnt;
	logic [2:0] k0, k1;
	logic [7:0] c0;
	logic [7:0] close_q_ch;

	assign close_q_ch = dq_q ? CH_DQUOTE : CH_SQUOTE;

	always_comb begin
		phase_d = phase_q;
		dq_d    = dq_q;
		esc_d   = esc_q;
		cnt     = 2'd0;
		k0      = KIND_NAME;
		k1      = KIND_OK;
		c0      = CH_NUL;
		unique case (phase_q)
			PH_BETWEEN: begin
				if (ch_s1 == CH_NUL) begin
					cnt = 2'd1; k0 = KIND_OK;
				end else if (is_space(ch_s1) || ch_s1 == CH_SEMI) begin
					// skip
				end else if (is_name(ch_s1)) begin
					cnt = 2'd1; k0 = KIND_NAME; c0 = to_upper(ch_s1);
					phase_d = PH_NAME;
				end else begin
					cnt = 2'd1; k0 = KIND_ERR;
					phase_d = PH_DISCARD;
				end
			end
			PH_NAME, PH_AFTERNAME: begin
				if (ch_s1 == CH_NUL) begin
					cnt = 2'd2; k0 = KIND_ERR; k1 = KIND_FAIL;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else if (phase_q == PH_NAME && is_name(ch_s1)) begin
					cnt = 2'd1; k0 = KIND_NAME; c0 = to_upper(ch_s1);
				end else if (is_space(ch_s1)) begin
					phase_d = PH_AFTERNAME;
				end else if (ch_s1 == CH_EQUAL) begin
					phase_d = PH_PREVALUE;
				end else begin
					cnt = 2'd1; k0 = KIND_ERR;
					phase_d = PH_DISCARD;
				end
			end
			PH_PREVALUE: begin
				if (ch_s1 == CH_NUL) begin
					cnt = 2'd2; k0 = KIND_REC; k1 = KIND_OK;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else if (is_space(ch_s1)) begin
					// skip
				end else if (ch_s1 == CH_SQUOTE || ch_s1 == CH_DQUOTE) begin
					dq_d = (ch_s1 == CH_DQUOTE);
					phase_d = PH_QUOTED;
				end else if (ch_s1 == CH_BSLASH) begin
					esc_d = 1'b0; phase_d = PH_ESCAPE;
				end else if (ch_s1 == CH_SEMI) begin
					cnt = 2'd1; k0 = KIND_REC;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else begin
					cnt = 2'd1; k0 = KIND_VALUE; c0 = ch_s1;
					phase_d = PH_BARE;
				end
			end
			PH_BARE: begin
				if (ch_s1 == CH_NUL) begin
					cnt = 2'd2; k0 = KIND_REC; k1 = KIND_OK;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else if (is_space(ch_s1) || ch_s1 == CH_SEMI) begin
					cnt = 2'd1; k0 = KIND_REC;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else if (ch_s1 == CH_BSLASH) begin
					esc_d = 1'b0; phase_d = PH_ESCAPE;
				end else begin
					cnt = 2'd1; k0 = KIND_VALUE; c0 = ch_s1;
				end
			end
			PH_QUOTED: begin
				if (ch_s1 == CH_NUL) begin
					cnt = 2'd2; k0 = KIND_REC; k1 = KIND_OK;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else if (ch_s1 == close_q_ch) begin
					cnt = 2'd1; k0 = KIND_REC;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else if (ch_s1 == CH_BSLASH) begin
					esc_d = 1'b1; phase_d = PH_ESCAPE;
				end else begin
					cnt = 2'd1; k0 = KIND_VALUE; c0 = ch_s1;
				end
			end
			PH_ESCAPE: begin
				if (ch_s1 == CH_NUL) begin
					// a trailing backslash is dropped
					cnt = 2'd2; k0 = KIND_REC; k1 = KIND_OK;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end else begin
					cnt = 2'd1; k0 = KIND_VALUE; c0 = ch_s1;
					phase_d = esc_q ? PH_QUOTED : PH_BARE;
				end
			end
			PH_DISCARD: begin
				if (ch_s1 == CH_NUL) begin
					cnt = 2'd1; k0 = KIND_FAIL;
					phase_d = PH_BETWEEN; dq_d = 1'b0; esc_d = 1'b0;
				end
			end
			default: begin
				phase_d = PH_BETWEEN;
			end
		endcase
	end

	always_comb begin
		res.cnt       = cnt;
		res.ent0.kind = k0;
		res.ent0.ch   = c0;
		res.ent0.last = (cnt == 2'd1);
		res.ent1.kind = k1;
		res.ent1.ch   = CH_NUL;
		res.ent1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BETWEEN;
			dq_q    <= 1'b0;
			esc_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			dq_q    <= dq_d;
			esc_q   <= esc_d;
		end
	end

endmodule

// File: rtl/core/kvcl_outq.sv
// ----------------------------------------------------------------------------
// kvcl_outq
// Small result queue: takes zero to two results a cycle, hands out one per pop.
// ----------------------------------------------------------------------------
module kvcl_outq import kvcl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  lex_out_t res,
	input  logic     pop,
	output result_t  head,
	output q_stat_t  stat
);

	result_t        slot_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   count_q;
	logic [1:0]     n_push;
	logic [QAW-1:0] wr_next;

	assign n_push  = push ? res.cnt : 2'd0;
	assign wr_next = wr_q + QAW'(1);

	assign head          = slot_q[rd_q];
	assign stat.nonempty = (count_q != '0);
	assign stat.room     = (count_q <= (QAW+1)'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			slot_q[wr_q] <= res.ent0;
		if (n_push == 2'd2)
			slot_q[wr_next] <= res.ent1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(n_push);
			rd_q    <= rd_q + QAW'(pop);
			count_q <= count_q + (QAW+1)'(n_push) - (QAW+1)'(pop);
		end
	end

endmodule

// File: rtl/core/key_value_config_lexer_core.sv
// ----------------------------------------------------------------------------
// key_value_config_lexer_core
// Streaming lexer for "name = value;" records, one text byte per transfer.
// ----------------------------------------------------------------------------
// Takes one byte per clock into an input register while in_stall is low; the
// byte's parse step is combinational and its results (name chars upper-cased,
// value chars, record end, text ok / syntax error / text failed) go into a
// four-entry result queue that drives the output. Results leave one per clock
// while out_stall is low. A byte that ends the text can give two results, so
// the input side holds whenever the queue has fewer than two free slots. With
// the output taken every cycle the block takes one byte per clock for as long
// as the results do not outnumber the bytes; a run of text-ending bytes that
// each give two results fills the queue and holds the input until it drains.
module key_value_config_lexer_core import kvcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] char_out,
	output logic       last
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       take;
	lex_out_t   res;
	result_t    head;
	q_stat_t    stat;

	assign take     = valid_s1 && stat.room;
	assign in_stall = valid_s1 && !stat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			ch_s1 <= char_in;
	end

	kvcl_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch_s1  (ch_s1),
		.res    (res)
	);

	kvcl_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.res    (res),
		.pop    (out_valid && !out_stall),
		.head   (head),
		.stat   (stat)
	);

	assign out_valid = stat.nonempty;
	assign kind      = head.kind;
	assign char_out  = head.ch;
	assign last      = head.last;

endmodule

// File: rtl/core/kvcl_checker.sv
// ----------------------------------------------------------------------------
// kvcl_checker
// Port-level checks on the lexer's result stream.
// ----------------------------------------------------------------------------
module kvcl_checker import kvcl_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] kind,
	input logic [7:0] char_out,
	input logic       last
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(char_out) &&
			$stable(last))
		else $error("result changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= KIND_FAIL)
		else $error("undefined result kind");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_NAME && kind != KIND_VALUE |-> char_out == CH_NUL)
		else $error("character on a non-character result");

	a_name_upper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NAME |-> is_name(char_out) &&
			!(char_out >= 8'h61 && char_out <= 8'h7A))
		else $error("name character not folded");

	// text end results always close the transfer group of their byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_OK || kind == KIND_FAIL) |-> last)
		else $error("end of text result not marked last");

endmodule

bind key_value_config_lexer_core kvcl_checker u_kvcl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.char_out  (char_out),
	.last      (last)
);

// File: sim/key_value_config_lexer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_config_lexer_core_tb
// Self-checking bench for the streaming "name = value" lexer core.
// ----------------------------------------------------------------------------
// Feeds text bytes through the input channel. A local lexer predicts the
// tokens that each accepted byte should produce and queues them. Every token
// transfer on the output side is checked field by field against that queue.
// The bench runs a directed pass over the corner cases, then random texts
// and raw byte noise under several sender and receiver idling mixes.
module key_value_config_lexer_core_tb;
	import kvcl_pkg::*;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic       last;
	} token_t;

	typedef enum logic [2:0] {
		P_IDLE, P_NAME, P_NAME_DONE, P_PRE_VALUE,
		P_BARE, P_QUOTED, P_ESCAPED, P_SKIP
	} lex_phase_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] char_in   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] char_out;
	logic       last;

	token_t     pending_tokens[$];
	bit   [7:0] text_buf[$];
	lex_phase_t phase      = P_IDLE;
	bit         dq_open    = 1'b0;
	bit         esc_quoted = 1'b0;
	int         mismatch_count = 0;
	int         send_idle_pct  = 0;
	int         stall_pct      = 0;

	key_value_config_lexer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.char_out  (char_out),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// ---------------- token prediction ----------------

	function automatic bit blank(input bit [7:0] c);
		return (c >= 8'd1) && (c <= CH_SPACE);
	endfunction

	function automatic bit ident(input bit [7:0] c);
		bit [7:0] low;
		low = c | 8'h20;
		return (c == 8'h5F) || (low >= 8'h61 && low <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic bit [7:0] fold(input bit [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? (c & 8'hDF) : c;
	endfunction

	function automatic void note(input logic [2:0] k, input logic [7:0] ch);
		pending_tokens.push_back('{kind: k, ch: ch, last: 1'b0});
	endfunction

	function automatic void lex_byte(input bit [7:0] c);
		int start;
		bit eot;
		start = pending_tokens.size();
		eot = (c == CH_NUL);
		case (phase)
			P_IDLE: begin
				if (eot) begin
					note(KIND_OK, 8'h00);
				end else if (blank(c) || c == CH_SEMI) begin
				end else if (ident(c)) begin
					note(KIND_NAME, fold(c));
					phase = P_NAME;
				end else begin
					note(KIND_ERR, 8'h00);
					phase = P_SKIP;
				end
			end
			P_NAME, P_NAME_DONE: begin
				if (eot) begin
					note(KIND_ERR, 8'h00);
					note(KIND_FAIL, 8'h00);
				end else if (phase == P_NAME && ident(c)) begin
					note(KIND_NAME, fold(c));
				end else if (blank(c)) begin
					phase = P_NAME_DONE;
				end else if (c == CH_EQUAL) begin
					phase = P_PRE_VALUE;
				end else begin
					note(KIND_ERR, 8'h00);
					phase = P_SKIP;
				end
			end
			P_PRE_VALUE: begin
				if (eot) begin
					note(KIND_REC, 8'h00);
					note(KIND_OK, 8'h00);
				end else if (blank(c)) begin
				end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
					dq_open = (c == CH_DQUOTE);
					phase = P_QUOTED;
				end else if (c == CH_BSLASH) begin
					esc_quoted = 1'b0;
					phase = P_ESCAPED;
				end else if (c == CH_SEMI) begin
					note(KIND_REC, 8'h00);
					phase = P_IDLE;
				end else begin
					note(KIND_VALUE, c);
					phase = P_BARE;
				end
			end
			P_BARE: begin
				if (eot) begin
					note(KIND_REC, 8'h00);
					note(KIND_OK, 8'h00);
				end else if (blank(c) || c == CH_SEMI) begin
					note(KIND_REC, 8'h00);
					phase = P_IDLE;
				end else if (c == CH_BSLASH) begin
					esc_quoted = 1'b0;
					phase = P_ESCAPED;
				end else begin
					note(KIND_VALUE, c);
				end
			end
			P_QUOTED: begin
				if (eot) begin
					note(KIND_REC, 8'h00);
					note(KIND_OK, 8'h00);
				end else if (c == (dq_open ? CH_DQUOTE : CH_SQUOTE)) begin
					note(KIND_REC, 8'h00);
					phase = P_IDLE;
				end else if (c == CH_BSLASH) begin
					esc_quoted = 1'b1;
					phase = P_ESCAPED;
				end else begin
					note(KIND_VALUE, c);
				end
			end
			P_ESCAPED: begin
				if (eot) begin
					note(KIND_REC, 8'h00);
					note(KIND_OK, 8'h00);
				end else begin
					note(KIND_VALUE, c);
					phase = esc_quoted ? P_QUOTED : P_BARE;
				end
			end
			default: begin
				if (eot)
					note(KIND_FAIL, 8'h00);
			end
		endcase
		// end of text always returns to the idle phase
		if (eot)
			phase = P_IDLE;
		if (phase == P_IDLE) begin
			dq_open = 1'b0;
			esc_quoted = 1'b0;
		end
		if (pending_tokens.size() > start)
			pending_tokens[pending_tokens.size() - 1].last = 1'b1;
	endfunction

	// ---------------- result checking ----------------

	always @(posedge clk) begin : check_tokens
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				$error("unexpected token: kind %0d char_out 0x%02h last %0d",
					kind, char_out, last);
				mismatch_count++;
			end else begin
				want = pending_tokens.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					mismatch_count++;
				end
				if (char_out !== want.ch) begin
					$error("char_out: expected 0x%02h, got 0x%02h", want.ch, char_out);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_byte(input bit [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			char_in = 8'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		char_in = c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		lex_byte(c);
	endtask

	// hold the sender until every predicted token has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic bit [7:0] rand_name_char();
		case ($urandom_range(3))
			0: return 8'h5F;
			1: return 8'h61 + 8'($urandom_range(25));
			2: return 8'h41 + 8'($urandom_range(25));
			default: return 8'h30 + 8'($urandom_range(9));
		endcase
	endfunction

	function automatic bit [7:0] rand_bare_char();
		bit [7:0] c;
		do
			c = 8'($urandom_range(33, 255));
		while (c == CH_SEMI || c == CH_BSLASH);
		return c;
	endfunction

	function automatic bit [7:0] rand_quoted_char(input bit [7:0] quote);
		bit [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == quote || c == CH_BSLASH);
		return c;
	endfunction

	function automatic void add_blanks(input int max_n);
		int n;
		n = $urandom_range(max_n);
		repeat (n)
			text_buf.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(1, 32)) : CH_SPACE);
	endfunction

	function automatic void add_record(input bit is_final, input bit broken);
		int start;
		int len;
		bit [7:0] quote;
		start = text_buf.size();
		add_blanks(2);
		if ($urandom_range(7) == 0)
			text_buf.push_back(CH_SEMI);
		len = $urandom_range(1, 6);
		repeat (len) text_buf.push_back(rand_name_char());
		add_blanks(2);
		text_buf.push_back(CH_EQUAL);
		add_blanks(2);
		len = $urandom_range(0, 6);
		if ($urandom_range(2) == 0) begin
			repeat (len) begin
				if ($urandom_range(9) == 0) begin
					text_buf.push_back(CH_BSLASH);
					text_buf.push_back(8'($urandom_range(1, 255)));
				end else begin
					text_buf.push_back(rand_bare_char());
				end
			end
			// an empty bare value needs ';', since blanks are skipped there
			if (!is_final || $urandom_range(1) == 0)
				text_buf.push_back((len == 0 || $urandom_range(1) == 0) ? CH_SEMI : CH_SPACE);
		end else begin
			quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
			text_buf.push_back(quote);
			repeat (len) begin
				if ($urandom_range(7) == 0) begin
					text_buf.push_back(CH_BSLASH);
					text_buf.push_back(8'($urandom_range(1, 255)));
				end else begin
					text_buf.push_back(rand_quoted_char(quote));
				end
			end
			// leave the closing quote off now and then on the final record
			if (!is_final || $urandom_range(3) != 0)
				text_buf.push_back(quote);
		end
		if (is_final && $urandom_range(7) == 0)
			text_buf.push_back(CH_BSLASH);
		if (broken)
			text_buf[$urandom_range(start, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
	endfunction

	task automatic test_special_cases();
		bit [7:0] seq[$];
		seq = '{CH_NUL,
			CH_SEMI, CH_SPACE, 8'd1, "a", CH_EQUAL, 8'hFF, CH_SEMI,
			"z", CH_NUL,
			CH_EQUAL, "q", CH_NUL,
			"_", "9", CH_EQUAL, CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_NUL,
			"b", CH_EQUAL, CH_BSLASH, CH_NUL,
			"c", CH_EQUAL, CH_NUL};
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic test_record_texts(input int n_bytes);
		int sent;
		int n_rec;
		sent = 0;
		while (sent < n_bytes) begin
			text_buf.delete();
			n_rec = $urandom_range(1, 4);
			for (int r = 0; r < n_rec; r++)
				add_record(r == n_rec - 1, $urandom_range(9) == 0);
			add_blanks(1);
			text_buf.push_back(CH_NUL);
			foreach (text_buf[i])
				send_byte(text_buf[i]);
			sent += text_buf.size();
		end
	endtask

	task automatic test_noise_bytes(input int n_bytes);
		bit [7:0] specials[$];
		specials = '{CH_NUL, CH_SPACE, CH_SEMI, CH_EQUAL, CH_BSLASH, CH_SQUOTE, CH_DQUOTE};
		repeat (n_bytes) begin
			if ($urandom_range(2) == 0)
				send_byte(specials[$urandom_range(specials.size() - 1)]);
			else
				send_byte(8'($urandom));
		end
		// close the text so the next test starts from the idle phase
		send_byte(CH_NUL);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_rate);
		send_idle_pct = idle_pct;
		stall_pct = stall_rate;
		test_record_texts(250);
		test_noise_bytes(40);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_special_cases();
		wait_drained();
		run_random_phase(0, 0);
		run_random_phase(81, 0);
		wait_drained();
		run_random_phase(0, 81);
		run_random_phase(7, 7);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
